// ===== hw/rtl/chained_hash_set_engine_macros.svh =====
// assertion macros for the chained hash set engine checker
// no dependencies; taken in by the checker file
`ifndef CHAINED_HASH_SET_ENGINE_MACROS_SVH
`define CHAINED_HASH_SET_ENGINE_MACROS_SVH

// property checked while out of reset
`define CHSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define CHSE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/chse_pkg.sv =====
// shared types, constants and the bucket remainder step for the hash set engine
// no dependencies
`default_nettype none
package chse_pkg;
    localparam int BUCKETS   = 10;
    localparam int POOL_SIZE = 256;
    localparam int NODE_W    = $clog2(POOL_SIZE);
    localparam int LINK_W    = NODE_W + 1;
    localparam int KEY_W     = 31;
    localparam int KEY_PAD   = 32;
    localparam int NIB_CNT   = KEY_PAD / 4;
    localparam int NIB_W     = $clog2(NIB_CNT);
    localparam int OP_W      = 3;
    localparam int STS_W     = 2;
    localparam int CNT_W     = 9;
    localparam int BKT_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_SIZE);

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_COUNT  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STS_W-1:0] STS_OK   = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL = 2'd1;
    localparam logic [STS_W-1:0] STS_MISS = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [BKT_W-1:0] bkt;
    } t_work;

    // remainder update by one nibble, most significant bit first
    function automatic logic [BKT_W-1:0] mod_step(input logic [BKT_W-1:0] rem,
                                                  input logic [3:0] nib);
        logic [BKT_W:0] r;
        r = {1'b0, rem};
        for (int i = 3; i >= 0; i--) begin
            r = {r[BKT_W-1:0], nib[i]};
            if (r >= (BKT_W+1)'(BUCKETS)) begin
                r = r - (BKT_W+1)'(BUCKETS);
            end
        end
        return r[BKT_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/chse_front.sv =====
// front end: accepts items and works out the bucket, one nibble a cycle
// depends on chse_pkg
`default_nettype none
module chse_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [chse_pkg::OP_W-1:0]    i_opcode,
    input  wire  [chse_pkg::KEY_W-1:0]   i_key_value,
    output logic                         o_wvalid,
    input  wire                          i_wready,
    output chse_pkg::t_work              o_wdata
);
    import chse_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MOD  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]         r_st;
    logic [NIB_W-1:0]   r_cnt;
    logic [KEY_PAD-1:0] r_sh;
    logic [BKT_W-1:0]   r_rem;
    logic [OP_W-1:0]    r_op;
    logic [KEY_W-1:0]   r_key;

    assign o_ready  = (r_st == F_IDLE);
    assign o_wvalid = (r_st == F_PUSH);
    assign o_wdata  = '{op: r_op, key: r_key, bkt: r_rem};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= F_IDLE;
        end else begin
            unique case (r_st)
                F_IDLE: if (i_valid) r_st <= F_MOD;
                F_MOD:  if (r_cnt == NIB_W'(NIB_CNT - 1)) r_st <= F_PUSH;
                F_PUSH: if (i_wready) r_st <= F_IDLE;
                default: r_st <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == F_IDLE && i_valid) begin
            r_op  <= i_opcode;
            r_key <= i_key_value;
            r_sh  <= KEY_PAD'(i_key_value);
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_st == F_MOD) begin
            r_rem <= mod_step(r_rem, r_sh[KEY_PAD-1 -: 4]);
            r_sh  <= r_sh << 4;
            r_cnt <= r_cnt + 1'b1;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/chse_queue.sv =====
// two-entry queue of classified items between front and back
// depends on chse_pkg
`default_nettype none
module chse_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_wvalid,
    output logic             o_wready,
    input  chse_pkg::t_work  i_wdata,
    output logic             o_rvalid,
    input  wire              i_rready,
    output chse_pkg::t_work  o_rdata
);
    import chse_pkg::*;

    t_work      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_wready = (r_cnt != 2'd2);
    assign o_rvalid = (r_cnt != 2'd0);
    assign o_rdata  = r_mem[r_rp];
    assign w_push   = i_wvalid && o_wready;
    assign w_pop    = o_rvalid && i_rready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_wdata;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/chse_back.sv =====
// back end: walks bucket chains in the node pool and produces results
// depends on chse_pkg
`default_nettype none
module chse_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_rvalid,
    output logic                         o_rready,
    input  chse_pkg::t_work              i_rdata,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic                         o_found,
    output logic [chse_pkg::STS_W-1:0]   o_status,
    output logic [chse_pkg::CNT_W-1:0]   o_entry_count
);
    import chse_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_INS  = 3'd1;
    localparam logic [2:0] B_INS2 = 3'd2;
    localparam logic [2:0] B_WALK = 3'd3;
    localparam logic [2:0] B_REM  = 3'd4;

    logic [KEY_W-1:0]  r_key_mem  [POOL_SIZE];
    logic [LINK_W-1:0] r_link_mem [POOL_SIZE];
    logic [POOL_SIZE-1:0] r_link_vld;
    logic [LINK_W-1:0] r_link_rd;
    logic [KEY_W-1:0]  r_key_rd;

    logic [2:0]        r_st, n_st;
    logic [OP_W-1:0]   r_op, n_op;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [BKT_W-1:0]  r_bkt, n_bkt;
    logic [LINK_W-1:0] r_p, n_p;
    logic [LINK_W-1:0] r_prev, n_prev;
    logic [LINK_W-1:0] r_steps, n_steps;
    logic [LINK_W-1:0] r_free, n_free;
    logic [CNT_W-1:0]  r_total, n_total;
    logic [LINK_W-1:0] r_head [BUCKETS];
    logic [LINK_W-1:0] n_head [BUCKETS];
    logic [LINK_W-1:0] r_tail [BUCKETS];
    logic [LINK_W-1:0] n_tail [BUCKETS];
    logic              r_out_valid, n_out_valid;
    logic              r_found, n_found;
    logic [STS_W-1:0]  r_status, n_status;
    logic [CNT_W-1:0]  r_cnt_out, n_cnt_out;

    logic              w_lwe, w_lre, w_kwe, w_kre, w_clr;
    logic [NODE_W-1:0] w_lwa, w_lra, w_kwa, w_kra;
    logic [LINK_W-1:0] w_lwd;
    logic [LINK_W-1:0] w_step1;

    assign o_valid       = r_out_valid;
    assign o_found       = r_found;
    assign o_status      = r_status;
    assign o_entry_count = r_cnt_out;
    assign o_rready      = (r_st == B_IDLE) && !r_out_valid;
    assign w_step1       = r_steps + 1'b1;

    always_comb begin
        n_st = r_st; n_op = r_op; n_key = r_key; n_bkt = r_bkt;
        n_p = r_p; n_prev = r_prev; n_steps = r_steps;
        n_free = r_free; n_total = r_total;
        n_head = r_head; n_tail = r_tail;
        n_out_valid = r_out_valid && !i_ready;
        n_found = r_found; n_status = r_status; n_cnt_out = r_cnt_out;
        w_lwe = 1'b0; w_lwa = '0; w_lwd = '0; w_lre = 1'b0; w_lra = '0;
        w_kwe = 1'b0; w_kwa = '0; w_kre = 1'b0; w_kra = '0; w_clr = 1'b0;

        unique case (r_st)
            B_IDLE: begin
                if (i_rvalid && !r_out_valid) begin
                    n_op  = i_rdata.op;
                    n_key = i_rdata.key;
                    n_bkt = i_rdata.bkt;
                    n_out_valid = 1'b1; n_found = 1'b0;
                    n_status = STS_OK; n_cnt_out = r_total;
                    case (i_rdata.op)
                        OP_INSERT: begin
                            if (r_free == NIL) begin
                                n_status = STS_FULL;
                            end else begin
                                n_out_valid = 1'b0;
                                w_lre = 1'b1; w_lra = r_free[NODE_W-1:0];
                                n_p = r_free; n_st = B_INS;
                            end
                        end
                        OP_FIND, OP_REMOVE: begin
                            if (r_head[i_rdata.bkt] == NIL) begin
                                n_status = STS_MISS;
                            end else begin
                                n_out_valid = 1'b0;
                                w_lre = 1'b1; w_lra = r_head[i_rdata.bkt][NODE_W-1:0];
                                w_kre = 1'b1; w_kra = r_head[i_rdata.bkt][NODE_W-1:0];
                                n_p = r_head[i_rdata.bkt]; n_prev = NIL;
                                n_steps = '0; n_st = B_WALK;
                            end
                        end
                        OP_CLEAR: begin
                            w_clr = 1'b1;
                            for (int i = 0; i < BUCKETS; i++) begin
                                n_head[i] = NIL; n_tail[i] = NIL;
                            end
                            n_free = '0; n_total = '0; n_cnt_out = '0;
                        end
                        default: ;
                    endcase
                end
            end
            B_INS: begin
                n_free = r_link_rd;
                w_kwe = 1'b1; w_kwa = r_p[NODE_W-1:0];
                w_lwe = 1'b1; w_lwa = r_p[NODE_W-1:0]; w_lwd = NIL;
                n_st = B_INS2;
            end
            B_INS2: begin
                if (r_tail[r_bkt] != NIL) begin
                    w_lwe = 1'b1; w_lwa = r_tail[r_bkt][NODE_W-1:0]; w_lwd = r_p;
                end else begin
                    n_head[r_bkt] = r_p;
                end
                n_tail[r_bkt] = r_p;
                n_total = r_total + 1'b1;
                n_out_valid = 1'b1; n_found = 1'b0; n_status = STS_OK;
                n_cnt_out = n_total; n_st = B_IDLE;
            end
            B_WALK: begin
                if (r_key_rd == r_key) begin
                    if (r_op == OP_REMOVE) begin
                        if (r_prev != NIL) begin
                            w_lwe = 1'b1; w_lwa = r_prev[NODE_W-1:0]; w_lwd = r_link_rd;
                        end else begin
                            n_head[r_bkt] = r_link_rd;
                        end
                        if (r_tail[r_bkt] == r_p) n_tail[r_bkt] = r_prev;
                        n_st = B_REM;
                    end else begin
                        n_out_valid = 1'b1; n_found = 1'b1; n_status = STS_OK;
                        n_cnt_out = r_total; n_st = B_IDLE;
                    end
                end else if (r_link_rd == NIL || w_step1 == LINK_W'(POOL_SIZE)) begin
                    n_out_valid = 1'b1; n_found = 1'b0; n_status = STS_MISS;
                    n_cnt_out = r_total; n_st = B_IDLE;
                end else begin
                    w_lre = 1'b1; w_lra = r_link_rd[NODE_W-1:0];
                    w_kre = 1'b1; w_kra = r_link_rd[NODE_W-1:0];
                    n_prev = r_p; n_p = r_link_rd; n_steps = w_step1;
                end
            end
            B_REM: begin
                w_lwe = 1'b1; w_lwa = r_p[NODE_W-1:0]; w_lwd = r_free;
                n_free = r_p;
                if (r_total != '0) n_total = r_total - 1'b1;
                n_out_valid = 1'b1; n_found = 1'b1; n_status = STS_OK;
                n_cnt_out = n_total; n_st = B_IDLE;
            end
            default: n_st = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= B_IDLE;
            r_out_valid <= 1'b0;
            r_free <= '0;
            r_total <= '0;
            for (int i = 0; i < BUCKETS; i++) begin
                r_head[i] <= NIL;
                r_tail[i] <= NIL;
            end
        end else begin
            r_st <= n_st;
            r_out_valid <= n_out_valid;
            r_free <= n_free;
            r_total <= n_total;
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_key <= n_key; r_bkt <= n_bkt;
        r_p <= n_p; r_prev <= n_prev; r_steps <= n_steps;
        r_found <= n_found; r_status <= n_status; r_cnt_out <= n_cnt_out;
    end

    // link store: an entry not yet written reads as its free list successor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clr) begin
            r_link_vld <= '0;
        end else if (w_lwe) begin
            r_link_vld[w_lwa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lwe) r_link_mem[w_lwa] <= w_lwd;
        if (w_lre) begin
            r_link_rd <= r_link_vld[w_lra] ? r_link_mem[w_lra]
                                            : LINK_W'(w_lra) + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_kwe) r_key_mem[w_kwa] <= r_key;
        if (w_kre) r_key_rd <= r_key_mem[w_kra];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/chained_hash_set_engine.sv =====
// top level of the chained hash set engine: front end, queue and back end
// depends on chse_pkg, chse_front, chse_queue, chse_back
`default_nettype none
// hash set with separate chaining over a pool of 256 nodes and 10 buckets;
// each item carries an opcode (insert, find, remove, count, clear) and a key,
// and gives exactly one result item with found, status and entry count.
// the front end takes an item and reduces the key modulo the bucket count
// one nibble a cycle, then hands the item on through a two-entry queue and
// takes no new item until the queue has accepted the last one.
// the back end registers the result straight from its idle state for count,
// clear, unknown opcodes, refused inserts and empty buckets; an insert goes
// on through B_INS and B_INS2, and a find or remove walks the chain in
// B_WALK, one read of the key and link memories per node, with B_REM after
// a matched remove. the back end takes the next item only in the cycle
// after its result is taken. front and back overlap, so the rate is set by
// the slower of the two. the result sits in an output register, so the
// front keeps taking items while a result waits until the queue is full.
// no clearing pass is needed after reset.
module chained_hash_set_engine (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [chse_pkg::OP_W-1:0]    i_opcode,
    input  wire  [chse_pkg::KEY_W-1:0]   i_key_value,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic                         o_found,
    output logic [chse_pkg::STS_W-1:0]   o_status,
    output logic [chse_pkg::CNT_W-1:0]   o_entry_count
);
    import chse_pkg::*;

    // front to queue
    logic  w_f_valid;
    logic  w_f_ready;
    t_work w_f_data;
    // queue to back
    logic  w_b_valid;
    logic  w_b_ready;
    t_work w_b_data;

    chse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_key_value (i_key_value),
        .o_wvalid    (w_f_valid),
        .i_wready    (w_f_ready),
        .o_wdata     (w_f_data)
    );

    chse_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wvalid (w_f_valid),
        .o_wready (w_f_ready),
        .i_wdata  (w_f_data),
        .o_rvalid (w_b_valid),
        .i_rready (w_b_ready),
        .o_rdata  (w_b_data)
    );

    // back end owns the pool memories, bucket heads and tails, and the count
    chse_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rvalid      (w_b_valid),
        .o_rready      (w_b_ready),
        .i_rdata       (w_b_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_found       (o_found),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/chse_checker.sv =====
// port-level checks for the chained hash set engine, bound to the top level
// depends on chse_pkg and chained_hash_set_engine_macros.svh
`default_nettype none
`include "chained_hash_set_engine_macros.svh"
module chse_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_valid,
    input wire                          i_ready,
    input wire                          o_found,
    input wire  [chse_pkg::STS_W-1:0]   o_status,
    input wire  [chse_pkg::CNT_W-1:0]   o_entry_count
);
    import chse_pkg::*;

    // a waiting result holds its payload
    `CHSE_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_entry_count) && $stable(o_found), "result changed while stalled")
    // a hit always reports ok
    `CHSE_ASSERT(a_found_ok, o_valid && o_found |-> o_status == STS_OK, "found with bad status")
    // a refused insert only when the pool is used up
    `CHSE_ASSERT(a_full_cnt, o_valid && o_status == STS_FULL |-> o_entry_count == CNT_W'(POOL_SIZE), "full status with free nodes")
    // entry count never exceeds the pool and the unused status code never shows
    `CHSE_ASSERT(a_cnt_range, o_valid |-> o_entry_count <= CNT_W'(POOL_SIZE) && o_status != 2'd3, "result out of range")
    // no result straight out of reset
    `CHSE_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !o_valid, "result after reset")
endmodule

bind chained_hash_set_engine chse_checker u_chk (.*);
`default_nettype wire
